// ===== design/source_address_deny_filter_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SOURCE_ADDRESS_DENY_FILTER_DEFINES_SVH
`define SOURCE_ADDRESS_DENY_FILTER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SADF_CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SADF_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/sadf_pkg.sv =====
`default_nettype none
package sadf_pkg;

   // Rule table depth and derived index width
   localparam int RULE_ENTRIES = 64;
   localparam int IDX_W = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
   localparam int CMP_W = 13;

   // Rule RAM word: {is_v6, deny, prefix_len, addr_high, addr_low}
   localparam int RULE_W = 138;

   localparam logic [15:0] TYPE_VLAN = 16'h8100;
   localparam logic [15:0] TYPE_QINQ = 16'h88A8;
   localparam logic [15:0] TYPE_IPV4 = 16'h0800;
   localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
   localparam logic [15:0] FRAG_MASK = 16'h1FFF;
   localparam logic [7:0]  V4_MAX_LEN = 8'd32;
   localparam logic [7:0]  V6_MAX_LEN = 8'd128;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_RULE = 1'b1;

   typedef struct packed {
      logic accept_byte;
      logic accept_rule;
      logic start_scan;
      logic scan_issue;
      logic finish;
   } sadf_cmd_type;

   typedef struct packed {
      logic eligible;
      logic scan_last;
      logic out_free;
   } sadf_status_type;

endpackage
`default_nettype wire

// ===== design/sadf_ram.sv =====
`default_nettype none
module sadf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                          wdata,
   output logic      [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== design/sadf_datapath.sv =====
`default_nettype none
module sadf_datapath
   import sadf_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire sadf_cmd_type    cmd,
   output sadf_status_type      status,
   input  wire logic [7:0]      req_packet_byte,
   input  wire logic            req_packet_last,
   input  wire logic [5:0]      req_rule_index,
   input  wire logic            req_rule_is_v6,
   input  wire logic [63:0]     req_rule_addr_high,
   input  wire logic [63:0]     req_rule_addr_low,
   input  wire logic [7:0]      req_rule_prefix_len,
   input  wire logic            req_rule_deny,
   input  wire logic            req_rule_valid,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic                 rsp_verdict,
   output logic [63:0]          rsp_seen_total,
   output logic [63:0]          rsp_dropped_total
);

   // Parser state
   logic [6:0]  pos_ff, pos_in;
   logic [15:0] type_ff, type_in;
   logic        tag_ff, tag_in;
   logic [15:0] frag_ff, frag_in;
   logic [63:0] src_high_ff, src_high_in;
   logic [63:0] src_low_ff, src_low_in;

   // Scan state
   logic [IDX_W-1:0] scan_addr_ff;
   logic             cmp_en_ff;
   logic             rd_valid_ff;
   logic             best_found_ff;
   logic [7:0]       best_len_ff;
   logic             best_deny_ff;
   logic [RULE_ENTRIES-1:0] valid_ff;

   // Output register; the totals double as the counters
   logic        rsp_valid_ff;
   logic        verdict_ff;
   logic [63:0] seen_ff;
   logic [63:0] dropped_ff;

   logic [6:0]  l3;
   logic [6:0]  rel;
   logic [7:0]  flen;
   logic        eligible;
   logic        clear_frame;
   logic        load_plain;
   logic        drop;

   // Rule write path
   logic             rule_ok;
   logic [IDX_W-1:0] wr_idx;
   logic [7:0]       plen_sat;
   logic             ram_we;
   logic [IDX_W-1:0] ram_addr;
   logic [RULE_W-1:0] ram_wdata;
   logic [RULE_W-1:0] ram_rdata;

   // Compare stage
   logic         e_v6;
   logic         e_deny;
   logic [7:0]   e_len;
   logic [127:0] a_word;
   logic [127:0] b_word;
   logic [127:0] mask;
   logic         hit;
   logic         frame_v6;

   // Header field extraction
   always_comb begin
      type_in     = type_ff;
      tag_in      = tag_ff;
      frag_in     = frag_ff;
      src_high_in = src_high_ff;
      src_low_in  = src_low_ff;
      if (pos_ff == 7'd12) begin
         type_in = {req_packet_byte, 8'h00};
      end else if (pos_ff == 7'd13) begin
         type_in = {type_ff[15:8], req_packet_byte};
         tag_in  = (type_in == TYPE_VLAN) || (type_in == TYPE_QINQ);
      end else if (tag_ff && pos_ff == 7'd16) begin
         type_in = {req_packet_byte, 8'h00};
      end else if (tag_ff && pos_ff == 7'd17) begin
         type_in = {type_ff[15:8], req_packet_byte};
      end
      l3  = tag_in ? 7'd18 : 7'd14;
      rel = pos_ff - l3;
      if (pos_ff >= l3) begin
         if (type_in == TYPE_IPV4) begin
            if (rel == 7'd6 || rel == 7'd7) begin
               frag_in = {frag_ff[7:0], req_packet_byte};
            end else if (rel >= 7'd12 && rel <= 7'd15) begin
               src_high_in = {src_high_ff[55:0], req_packet_byte};
            end
         end else if (type_in == TYPE_IPV6) begin
            if (rel >= 7'd8 && rel <= 7'd15) begin
               src_high_in = {src_high_ff[55:0], req_packet_byte};
            end else if (rel >= 7'd16 && rel <= 7'd23) begin
               src_low_in = {src_low_ff[55:0], req_packet_byte};
            end
         end
      end
      pos_in = (pos_ff == 7'd127) ? pos_ff : pos_ff + 7'd1;
   end

   // Frame needs a lookup if its header is complete and not a later fragment
   always_comb begin
      flen     = {1'b0, pos_ff} + 8'd1;
      eligible = 1'b0;
      if (flen >= 8'd14 && !(tag_in && flen < 8'd18)) begin
         if (type_in == TYPE_IPV4) begin
            eligible = (flen >= {1'b0, l3} + 8'd20) &&
                       ((frag_in & FRAG_MASK) == 16'h0000);
         end else if (type_in == TYPE_IPV6) begin
            eligible = flen >= {1'b0, l3} + 8'd40;
         end
      end
   end

   assign status.eligible = eligible;
   assign load_plain      = cmd.accept_byte && req_packet_last && !eligible;
   assign clear_frame     = load_plain || cmd.finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         type_ff     <= '0;
         tag_ff      <= 1'b0;
         frag_ff     <= '0;
         src_high_ff <= '0;
         src_low_ff  <= '0;
      end else if (clear_frame) begin
         pos_ff      <= '0;
         type_ff     <= '0;
         tag_ff      <= 1'b0;
         frag_ff     <= '0;
         src_high_ff <= '0;
         src_low_ff  <= '0;
      end else if (cmd.accept_byte) begin
         pos_ff      <= pos_in;
         type_ff     <= type_in;
         tag_ff      <= tag_in;
         frag_ff     <= frag_in;
         src_high_ff <= src_high_in;
         src_low_ff  <= src_low_in;
      end
   end

   // Rule write: range check and prefix saturation
   always_comb begin
      rule_ok  = CMP_W'(req_rule_index) < CMP_W'(RULE_ENTRIES);
      wr_idx   = IDX_W'(req_rule_index);
      plen_sat = req_rule_prefix_len;
      if (!req_rule_is_v6 && req_rule_prefix_len > V4_MAX_LEN) begin
         plen_sat = V4_MAX_LEN;
      end
      if (req_rule_is_v6 && req_rule_prefix_len > V6_MAX_LEN) begin
         plen_sat = V6_MAX_LEN;
      end
      ram_we    = cmd.accept_rule && rule_ok;
      ram_addr  = cmd.scan_issue ? scan_addr_ff : wr_idx;
      ram_wdata = {req_rule_is_v6, req_rule_deny, plen_sat,
                   req_rule_addr_high, req_rule_addr_low};
   end

   sadf_ram #(
      .WIDTH (RULE_W),
      .DEPTH (RULE_ENTRIES)
   ) u_rule_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Entry valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ram_we) begin
         valid_ff[wr_idx] <= req_rule_valid;
      end
   end

   // Scan address and read alignment
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         cmp_en_ff    <= 1'b0;
      end else begin
         cmp_en_ff <= cmd.scan_issue;
         if (cmd.start_scan) begin
            scan_addr_ff <= '0;
         end else if (cmd.scan_issue) begin
            scan_addr_ff <= scan_addr_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[scan_addr_ff];
   end

   assign status.scan_last = scan_addr_ff == IDX_W'(RULE_ENTRIES - 1);

   // Prefix compare of one entry against the captured source
   always_comb begin
      e_v6     = ram_rdata[137];
      e_deny   = ram_rdata[136];
      e_len    = ram_rdata[135:128];
      frame_v6 = type_ff == TYPE_IPV6;
      if (frame_v6) begin
         a_word = {src_high_ff, src_low_ff};
         b_word = ram_rdata[127:0];
      end else begin
         a_word = {src_high_ff[31:0], 96'h0};
         b_word = {ram_rdata[127:96], 96'h0};
      end
      mask = ~128'h0 << (V6_MAX_LEN - e_len);
      hit  = rd_valid_ff && (e_v6 == frame_v6) && (((a_word ^ b_word) & mask) == 128'h0);
   end

   // Longest match; strict compare keeps the lowest index on a tie
   always_ff @(posedge clock) begin
      if (cmd.start_scan) begin
         best_found_ff <= 1'b0;
         best_len_ff   <= '0;
         best_deny_ff  <= 1'b0;
      end else if (cmp_en_ff && hit && (!best_found_ff || e_len > best_len_ff)) begin
         best_found_ff <= 1'b1;
         best_len_ff   <= e_len;
         best_deny_ff  <= e_deny;
      end
   end

   // Result register and counters
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign drop            = cmd.finish && best_found_ff && best_deny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         verdict_ff   <= 1'b0;
         seen_ff      <= '0;
         dropped_ff   <= '0;
      end else if (load_plain || cmd.finish) begin
         rsp_valid_ff <= 1'b1;
         verdict_ff   <= drop;
         seen_ff      <= seen_ff + 64'd1;
         dropped_ff   <= drop ? dropped_ff + 64'd1 : dropped_ff;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_verdict       = verdict_ff;
   assign rsp_seen_total    = seen_ff;
   assign rsp_dropped_total = dropped_ff;

endmodule
`default_nettype wire

// ===== design/sadf_controller.sv =====
`default_nettype none
module sadf_controller
   import sadf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_op,
   input  wire logic             req_packet_last,
   input  wire sadf_status_type  status,
   output sadf_cmd_type          cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       accept;

   // Input stalls from the start of a scan until its result is written, and on a last byte while the result is held
   assign req_stall = (state_ff != ST_IDLE) ||
                      (req_op == OP_BYTE && req_packet_last && !status.out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in        = state_ff;
      cmd.accept_byte = accept && req_op == OP_BYTE;
      cmd.accept_rule = accept && req_op == OP_RULE;
      cmd.start_scan  = 1'b0;
      cmd.scan_issue  = 1'b0;
      cmd.finish      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept_byte && req_packet_last && status.eligible) begin
               cmd.start_scan = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/source_address_deny_filter.sv =====
// Source-address deny filter. Frame bytes (req_op 0) and rule writes (req_op 1)
// share one input channel. On the last byte of a frame carrying a complete IPv4
// (not a later fragment) or IPv6 header, the block scans the rule RAM through its
// single read port, one entry per cycle, and holds req_stall high through its
// scan, drain and finish states, longer while an earlier result is still held,
// before the result appears; any other last byte gives its result the next
// cycle. A last byte also stalls while an earlier result is still held.
// One result per frame: verdict plus wrapping seen and dropped totals. Rule
// valid bits clear at reset, so the table is usable straight away.
`default_nettype none
module source_address_deny_filter
   import sadf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_packet_byte,
   input  wire logic        req_packet_last,
   input  wire logic [5:0]  req_rule_index,
   input  wire logic        req_rule_is_v6,
   input  wire logic [63:0] req_rule_addr_high,
   input  wire logic [63:0] req_rule_addr_low,
   input  wire logic [7:0]  req_rule_prefix_len,
   input  wire logic        req_rule_deny,
   input  wire logic        req_rule_valid,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_verdict,
   output logic [63:0]      rsp_seen_total,
   output logic [63:0]      rsp_dropped_total
);

   sadf_cmd_type    cmd;
   sadf_status_type status;

   sadf_controller u_controller (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_packet_last (req_packet_last),
      .status          (status),
      .cmd             (cmd)
   );

   sadf_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_packet_byte     (req_packet_byte),
      .req_packet_last     (req_packet_last),
      .req_rule_index      (req_rule_index),
      .req_rule_is_v6      (req_rule_is_v6),
      .req_rule_addr_high  (req_rule_addr_high),
      .req_rule_addr_low   (req_rule_addr_low),
      .req_rule_prefix_len (req_rule_prefix_len),
      .req_rule_deny       (req_rule_deny),
      .req_rule_valid      (req_rule_valid),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_verdict         (rsp_verdict),
      .rsp_seen_total      (rsp_seen_total),
      .rsp_dropped_total   (rsp_dropped_total)
   );

endmodule
`default_nettype wire

// ===== design/sadf_checker.sv =====
`default_nettype none
`include "source_address_deny_filter_defines.svh"
module sadf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_verdict,
   input wire logic [63:0] rsp_seen_total,
   input wire logic [63:0] rsp_dropped_total
);

   // Held result stays put
   `SADF_CHECK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_seen_total), "stalled result changed")

   // Seen total moves by at most one per cycle
   `SADF_CHECK_NEXT(a_seen_step, 1'b1, $stable(rsp_seen_total) || (rsp_seen_total == $past(rsp_seen_total) + 64'd1), "seen total jumped")

   // Dropped total only grows with a drop verdict
   `SADF_CHECK_NEXT(a_drop_step, 1'b1, $stable(rsp_dropped_total) || ((rsp_dropped_total == $past(rsp_dropped_total) + 64'd1) && rsp_verdict), "dropped total moved without drop")

   // Dropped total moves only with a new result
   `SADF_CHECK_NEXT(a_drop_with_seen, 1'b1, !$stable(rsp_seen_total) || $stable(rsp_dropped_total), "dropped total moved alone")

endmodule

bind source_address_deny_filter sadf_checker u_sadf_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_verdict       (rsp_verdict),
   .rsp_seen_total    (rsp_seen_total),
   .rsp_dropped_total (rsp_dropped_total)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;
   import sadf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        op;
      logic [7:0]  pbyte;
      logic        plast;
      logic [5:0]  idx;
      logic        is_v6;
      logic [63:0] ahi;
      logic [63:0] alo;
      logic [7:0]  plen;
      logic        deny;
      logic        vld;
   } req_item_type;

   typedef struct {
      logic        verdict;
      logic [63:0] seen;
      logic [63:0] dropped;
   } verdict_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_op = 0;
   logic [7:0] req_packet_byte = 0;
   logic req_packet_last = 0;
   logic [5:0] req_rule_index = 0;
   logic req_rule_is_v6 = 0;
   logic [63:0] req_rule_addr_high = 0;
   logic [63:0] req_rule_addr_low = 0;
   logic [7:0] req_rule_prefix_len = 0;
   logic req_rule_deny = 0;
   logic req_rule_valid = 0;
   logic rsp_valid;
   logic rsp_stall = 1;
   logic rsp_verdict;
   logic [63:0] rsp_seen_total;
   logic [63:0] rsp_dropped_total;

   source_address_deny_filter u_top (.*);

   always #4 clock = ~clock;

   // Predictor state
   logic        tbl_valid [64];
   logic        tbl_v6 [64];
   logic        tbl_deny [64];
   logic [7:0]  tbl_len [64];
   logic [63:0] tbl_hi [64];
   logic [63:0] tbl_lo [64];
   logic [6:0]  pos;
   logic [15:0] etype;
   logic        is_tagged;
   logic [15:0] frag;
   logic [63:0] src_hi, src_lo;
   logic [63:0] seen_cnt, drop_cnt;

   req_item_type pending_items[$];
   verdict_type  expected_verdicts[$];
   int        errors = 0;
   int        items_done = 0;
   bit        stim_done = 0;
   int        hold_off = 0;

   function automatic bit top_match(logic [63:0] a, logic [63:0] b, int unsigned n);
      if (n == 0) return 1;
      if (n > 64) n = 64;
      return ((a ^ b) >> (64 - n)) == 0;
   endfunction

   function automatic bit lpm_deny(bit v6);
      int best;
      int unsigned best_len, n;
      bit hit;
      best = -1;
      best_len = 0;
      for (int i = 0; i < 64; i++) begin
         if (!tbl_valid[i] || tbl_v6[i] != v6) continue;
         n = tbl_len[i];
         if (!v6)
            hit = top_match(src_hi << 32, {tbl_hi[i][63:32], 32'h0}, n);
         else if (n <= 64)
            hit = top_match(src_hi, tbl_hi[i], n);
         else
            hit = (src_hi == tbl_hi[i]) && top_match(src_lo, tbl_lo[i], n - 64);
         if (hit && (best < 0 || n > best_len)) begin
            best = i;
            best_len = n;
         end
      end
      return best >= 0 && tbl_deny[best];
   endfunction

   function automatic void clear_parser();
      pos = 0; etype = 0; is_tagged = 0; frag = 0; src_hi = 0; src_lo = 0;
   endfunction

   // Advance the filter model by one accepted transfer
   function automatic void filter_step(req_item_type it);
      int unsigned p, l3, r, flen;
      logic [7:0] n;
      bit drop;
      verdict_type v;
      drop = 0;
      if (it.op == OP_RULE) begin
         n = it.plen;
         if (!it.is_v6 && n > V4_MAX_LEN) n = V4_MAX_LEN;
         if (it.is_v6 && n > V6_MAX_LEN) n = V6_MAX_LEN;
         tbl_valid[it.idx] = it.vld;
         tbl_v6[it.idx] = it.is_v6;
         tbl_deny[it.idx] = it.deny;
         tbl_len[it.idx] = n;
         tbl_hi[it.idx] = it.ahi;
         tbl_lo[it.idx] = it.alo;
         return;
      end
      p = pos;
      if (p == 12) etype = {it.pbyte, 8'h0};
      else if (p == 13) begin
         etype[7:0] = it.pbyte;
         is_tagged = etype == TYPE_VLAN || etype == TYPE_QINQ;
      end else if (is_tagged && p == 16) etype = {it.pbyte, 8'h0};
      else if (is_tagged && p == 17) etype[7:0] = it.pbyte;
      l3 = is_tagged ? 18 : 14;
      if (p >= l3) begin
         r = p - l3;
         if (etype == TYPE_IPV4) begin
            if (r == 6 || r == 7) frag = {frag[7:0], it.pbyte};
            else if (r >= 12 && r <= 15) src_hi = {src_hi[55:0], it.pbyte};
         end else if (etype == TYPE_IPV6) begin
            if (r >= 8 && r <= 15) src_hi = {src_hi[55:0], it.pbyte};
            else if (r >= 16 && r <= 23) src_lo = {src_lo[55:0], it.pbyte};
         end
      end
      if (!it.plast) begin
         if (pos < 127) pos++;
         return;
      end
      flen = p + 1;
      if (flen >= 14 && !(is_tagged && flen < 18)) begin
         if (etype == TYPE_IPV4) begin
            if (flen >= l3 + 20 && (frag & FRAG_MASK) == 0) drop = lpm_deny(0);
         end else if (etype == TYPE_IPV6) begin
            if (flen >= l3 + 40) drop = lpm_deny(1);
         end
      end
      seen_cnt++;
      if (drop) drop_cnt++;
      v.verdict = drop;
      v.seen = seen_cnt;
      v.dropped = drop_cnt;
      expected_verdicts.push_back(v);
      clear_parser();
   endfunction

   function automatic req_item_type rule_item(int idx, bit v6, logic [63:0] hi,
                                              logic [63:0] lo, int n, bit deny, bit vld);
      req_item_type it;
      it = '{default: '0};
      it.op = OP_RULE; it.idx = 6'(idx); it.is_v6 = v6; it.ahi = hi; it.alo = lo;
      it.plen = 8'(n); it.deny = deny; it.vld = vld;
      it.pbyte = 8'($urandom); it.plast = 1'($urandom);
      return it;
   endfunction

   function automatic void push_byte(logic [7:0] b, bit last);
      req_item_type it;
      it = '{default: '0};
      it.op = OP_BYTE; it.pbyte = b; it.plast = last;
      it.idx = 6'($urandom); it.ahi = {$urandom, $urandom};
      pending_items.push_back(it);
   endfunction

   // Queue a frame; ety picks the family, len the byte count
   function automatic void push_frame(logic [15:0] tag_type, logic [15:0] ety,
                                      logic [63:0] shi, logic [63:0] slo,
                                      logic [15:0] fr, int len);
      logic [7:0] hdr[$];
      for (int i = 0; i < 12; i++) hdr.push_back(8'($urandom));
      if (tag_type != 0) begin
         hdr.push_back(tag_type[15:8]); hdr.push_back(tag_type[7:0]);
         hdr.push_back(8'($urandom)); hdr.push_back(8'($urandom));
      end
      hdr.push_back(ety[15:8]); hdr.push_back(ety[7:0]);
      if (ety == TYPE_IPV4) begin
         for (int i = 0; i < 6; i++) hdr.push_back(8'($urandom));
         hdr.push_back(fr[15:8]); hdr.push_back(fr[7:0]);
         for (int i = 0; i < 4; i++) hdr.push_back(8'($urandom));
         for (int i = 0; i < 4; i++) hdr.push_back(shi[31 - 8*i -: 8]);
      end else begin
         for (int i = 0; i < 8; i++) hdr.push_back(8'($urandom));
         for (int i = 0; i < 8; i++) hdr.push_back(shi[63 - 8*i -: 8]);
         for (int i = 0; i < 8; i++) hdr.push_back(slo[63 - 8*i -: 8]);
      end
      for (int i = 0; i < len; i++)
         push_byte(i < hdr.size() ? hdr[i] : 8'($urandom), i == len - 1);
   endfunction

   logic [63:0] v4_pool[4];
   logic [63:0] v6hi_pool[4];
   logic [63:0] v6lo_pool[4];

   function automatic void random_frame();
      int k, len;
      logic [15:0] tg, et, fr;
      logic [63:0] hi, lo;
      k = $urandom_range(0, 3);
      case ($urandom_range(0, 5))
         0: tg = TYPE_VLAN;
         1: tg = TYPE_QINQ;
         default: tg = 16'h0;
      endcase
      case ($urandom_range(0, 9))
         0: et = TYPE_VLAN;
         1: et = 16'h0806;
         2: et = 16'($urandom);
         3, 4, 5: et = TYPE_IPV4;
         default: et = TYPE_IPV6;
      endcase
      fr = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom) & 16'hE000;
      hi = $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : v6hi_pool[k];
      lo = $urandom_range(0, 1) ? {$urandom, $urandom} : v6lo_pool[k];
      if (et == TYPE_IPV4)
         hi = $urandom_range(0, 3) == 0 ? {32'h0, $urandom} : {32'h0, v4_pool[k][63:32]}
              ^ (64'($urandom_range(0, 1)) << $urandom_range(0, 31));
      else
         lo ^= 64'($urandom_range(0, 1)) << $urandom_range(0, 63);
      if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 60);
      else len = (tg != 0 ? 18 : 14) + (et == TYPE_IPV4 ? 20 : 40) + $urandom_range(0, 12);
      if ($urandom_range(0, 40) == 0) len = $urandom_range(120, 140);
      push_frame(tg, et, hi, lo, fr, len);
   endfunction

   function automatic void random_rule();
      int k;
      bit v6;
      k = $urandom_range(0, 3);
      v6 = 1'($urandom);
      pending_items.push_back(rule_item($urandom_range(0, 63), v6,
         v6 ? v6hi_pool[k] : v4_pool[k], v6lo_pool[k],
         $urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
            : (v6 ? $urandom_range(0, 128) : $urandom_range(0, 32)),
         1'($urandom), $urandom_range(0, 4) != 0));
   endfunction

   // Stimulus
   initial begin
      for (int i = 0; i < 64; i++) begin
         tbl_valid[i] = 0; tbl_v6[i] = 0; tbl_deny[i] = 0; tbl_len[i] = 0;
         tbl_hi[i] = 0; tbl_lo[i] = 0;
      end
      clear_parser();
      seen_cnt = 0; drop_cnt = 0;
      for (int i = 0; i < 4; i++) begin
         v4_pool[i] = {$urandom, 32'h0};
         v6hi_pool[i] = {$urandom, $urandom};
         v6lo_pool[i] = {$urandom, $urandom};
      end
      // Directed: empty table, then catch-all deny and lower-index/longer allow
      push_frame(0, TYPE_IPV4, 64'hFFFF_FFFF, 0, 0, 34);
      pending_items.push_back(rule_item(63, 0, 64'hFFFF_FFFF_FFFF_FFFF,
                                        64'hFFFF_FFFF_FFFF_FFFF, 0, 1, 1));
      pending_items.push_back(rule_item(62, 1, 0, 0, 255, 1, 1));
      pending_items.push_back(rule_item(0, 1, 0, 0, 200, 0, 1));
      pending_items.push_back(rule_item(1, 0, 64'hC0A8_0000_0000_0000, 0, 16, 0, 1));
      pending_items.push_back(rule_item(2, 0, 64'hC0A8_0000_0000_0000, 0, 16, 1, 1));
      push_frame(0, TYPE_IPV4, 64'h0A00_0001, 0, 0, 34);
      push_frame(0, TYPE_IPV4, 64'hC0A8_0101, 0, 0, 34);
      push_frame(TYPE_VLAN, TYPE_IPV4, 64'h0A00_0001, 0, 0, 38);
      push_frame(0, TYPE_IPV4, 64'h0A00_0001, 0, 16'h0001, 34);
      push_frame(0, TYPE_IPV4, 64'h0A00_0001, 0, 16'hE000, 34);
      push_frame(0, TYPE_IPV4, 64'h0A00_0001, 0, 0, 33);
      push_frame(0, TYPE_IPV6, 0, 0, 0, 54);
      push_frame(0, TYPE_IPV6, 64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 54);
      push_frame(0, TYPE_IPV6, 0, 0, 0, 53);
      push_frame(TYPE_QINQ, TYPE_IPV6, 0, 1, 0, 58);
      push_frame(TYPE_VLAN, TYPE_VLAN, 0, 0, 0, 60);
      push_frame(0, 16'h0806, 0, 0, 0, 60);
      push_frame(0, TYPE_IPV4, 0, 0, 0, 1);
      push_frame(TYPE_VLAN, TYPE_IPV4, 0, 0, 0, 16);
      push_frame(0, TYPE_IPV4, 0, 0, 0, 135);
      // Rule write in mid-frame, then clear the catch-alls
      push_frame(0, TYPE_IPV4, 64'h0A00_0001, 0, 0, 34);
      pending_items.insert(pending_items.size() - 5, rule_item(3, 0, 0, 0, 40, 0, 1));
      pending_items.push_back(rule_item(63, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(rule_item(62, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(rule_item(3, 0, 0, 0, 0, 0, 0));
      // Random part: mostly well-formed frames, occasional rule updates
      while (pending_items.size() < 1650) begin
         if ($urandom_range(0, 5) == 0) random_rule();
         else random_frame();
      end
      stim_done = 1;
   end

   // Reset
   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
   end

   // Driver
   int gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            filter_step(pending_items.pop_front());
            items_done++;
            gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
         end
         if ((req_valid && req_stall) || (gap == 0 && pending_items.size() > 0)) begin
            req_valid <= 1;
            if (!(req_valid && req_stall)) begin
               req_op <= pending_items[0].op;
               req_packet_byte <= pending_items[0].pbyte;
               req_packet_last <= pending_items[0].plast;
               req_rule_index <= pending_items[0].idx;
               req_rule_is_v6 <= pending_items[0].is_v6;
               req_rule_addr_high <= pending_items[0].ahi;
               req_rule_addr_low <= pending_items[0].alo;
               req_rule_prefix_len <= pending_items[0].plen;
               req_rule_deny <= pending_items[0].deny;
               req_rule_valid <= pending_items[0].vld;
            end
         end else begin
            req_valid <= 0;
            if (gap > 0) gap--;
         end
      end
   end

   // Receiver stall, with one long hold-off early on
   int rgap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1;
      end else if (items_done > 300 && items_done < 320 && hold_off == 0) begin
         hold_off <= 400;
         rsp_stall <= 1;
      end else if (hold_off > 1) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1;
      end else begin
         if (hold_off == 1) hold_off <= -1;
         if (rsp_valid && !rsp_stall)
            rgap = $urandom_range(0, 2) == 0 ? $urandom_range(0, 16) : 0;
         else if (rgap > 0)
            rgap--;
         rsp_stall <= rgap != 0;
      end
   end

   // Monitor
   int watchdog = 0;
   always @(posedge clock) begin
      verdict_type e;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) watchdog = 0;
         else watchdog++;
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result transfer");
            end else begin
               e = expected_verdicts.pop_front();
               if (rsp_verdict !== e.verdict || rsp_seen_total !== e.seen ||
                   rsp_dropped_total !== e.dropped) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp v=%0d s=%0d d=%0d got v=%0d s=%0d d=%0d",
                              e.verdict, e.seen, e.dropped, rsp_verdict,
                              rsp_seen_total, rsp_dropped_total);
               end
            end
         end
         if (watchdog > 5000) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   // End of run
   initial begin
      wait (stim_done);
      wait (pending_items.size() == 0 && !req_valid);
      wait (expected_verdicts.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_verdicts.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+design
design/sadf_pkg.sv
design/sadf_ram.sv
design/sadf_datapath.sv
design/sadf_controller.sv
design/source_address_deny_filter.sv
design/sadf_checker.sv
tb/sv/tb.sv
